/* rtl/trf_pkg.sv */
// Shared constants, types and helpers of the trefoil surface point pipeline.
// Used by every other file of the block; depends on nothing.
`timescale 1ns / 1ps

package trf_pkg;

  // Field widths and number formats
  localparam int ANGLE_BITS    = 16;
  localparam int OUT_FRAC_BITS = 16;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 20;
  localparam int SIN_W         = 32;   // signed Q30 sine/cosine
  localparam int DEN_W         = 32;   // 2 + cos, unsigned Q30
  localparam int MAG_W         = 33;   // numerator magnitude, Q30
  localparam int QUO_W         = OUT_FRAC_BITS + 3;
  localparam int Z_SH          = 54 - OUT_FRAC_BITS;

  // Pipeline stage numbers
  localparam int ST_SIN   = 6;             // sine units deliver here
  localparam int ST_MIX   = 7;             // numerators and denominators
  localparam int ST_DIV0  = 8;             // first divider step
  localparam int ST_ZMUL  = 8;
  localparam int ST_ZRND  = 9;
  localparam int ST_ZPROD = 10;
  localparam int ST_ZOUT  = 11;
  localparam int ST_LAST  = ST_DIV0 + QUO_W;  // output register
  localparam int Z_DLY    = ST_LAST - 1 - ST_ZOUT;

  // Polynomial coefficients, Q30
  localparam logic [30:0] POLY_C1 = 31'd1686629713;
  localparam logic [30:0] POLY_C3 = 31'd693598668;
  localparam logic [30:0] POLY_C5 = 31'd85569306;
  localparam logic [30:0] POLY_C7 = 31'd5026995;

  typedef logic [ANGLE_BITS-1:0]   phase_t;
  typedef logic signed [OUT_W-1:0] coord_t;

  localparam phase_t ANGLE_QUARTER = phase_t'(1) << (ANGLE_BITS - 2);
  localparam phase_t ANGLE_THIRD   = ANGLE_BITS'((2 ** ANGLE_BITS + 1) / 3);

  localparam logic [63:0] SAT_POS = 64'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [63:0] SAT_NEG = 64'd1 << (OUT_W - 1);

  // Scale a 16-bit turn fraction to the internal phase width
  function automatic phase_t to_phase(input logic [IN_W-1:0] a);
    logic [IN_W+ANGLE_BITS-1:0] ext;
    ext = {a, {ANGLE_BITS{1'b0}}};
    return ext[IN_W+ANGLE_BITS-1 -: ANGLE_BITS];
  endfunction

  // Apply sign to a magnitude and saturate to the output range
  function automatic coord_t sat_coord(input logic neg, input logic [63:0] mag);
    coord_t r;
    if (!neg) begin
      if (mag > SAT_POS) r = {1'b0, {(OUT_W-1){1'b1}}};
      else               r = coord_t'(mag[OUT_W-1:0]);
    end else begin
      if (mag > SAT_NEG) r = {1'b1, {(OUT_W-1){1'b0}}};
      else               r = -coord_t'(mag[OUT_W-1:0]);
    end
    return r;
  endfunction

endpackage

/* rtl/trf_in_if.sv */
// Input channel: one (u, v) parameter pair per transaction.
// Depends on trf_pkg for field widths.
`timescale 1ns / 1ps

interface trf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [trf_pkg::IN_W-1:0]   angle_u;
  logic signed [trf_pkg::IN_W-1:0]   angle_v;

  modport source (output valid, angle_u, angle_v, input ready);
  modport sink   (input valid, angle_u, angle_v, output ready);
endinterface

/* rtl/trf_out_if.sv */
// Output channel: one surface point per transaction.
// Depends on trf_pkg for field widths.
`timescale 1ns / 1ps

interface trf_out_if;
  logic              valid;
  logic              ready;
  trf_pkg::coord_t   point_x;
  trf_pkg::coord_t   point_y;
  trf_pkg::coord_t   point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

/* rtl/trefoil_surface_point.sv */
// Tranguloid trefoil surface point: (u, v) in, (x, y, z) in Q3.16 out.
// Depends on trf_pkg, trf_in_if, trf_out_if, trf_sincos and trf_div.
//
//   channel | dir | handshake   | payload
//   in_i    | in  | valid/ready | angle_u, angle_v (signed Q0.15 of pi)
//   out_o   | out | valid/ready | point_x, point_y, point_z (signed Q3.16)
//
// One transaction per cycle while out_o is ready. The six-stage sine units,
// one mix stage and the 19-step quotient pipeline feed the output register.
// Every stage has its own valid bit and loads when it is empty or the next
// stage moves, so bubbles close up and a stalled output keeps accepting
// until the pipeline is full. Reset clears only the valid bits.
`timescale 1ns / 1ps

module trefoil_surface_point (
  input  logic            clk_i,
  input  logic            rst_ni,
  trf_in_if.sink          in_i,
  trf_out_if.source       out_o
);

  localparam int AB   = trf_pkg::ANGLE_BITS;
  localparam int LAST = trf_pkg::ST_LAST;
  localparam int SW   = trf_pkg::SIN_W;
  localparam int DW   = trf_pkg::DEN_W;
  localparam int MW   = trf_pkg::MAG_W;
  localparam int QW   = trf_pkg::QUO_W;
  localparam int ZD   = trf_pkg::Z_DLY;

  logic [LAST+1:1] rdy;
  logic [LAST:1]   vld_q;
  logic [LAST:1]   vld_prev;

  // Stage handshake: load when empty or when the next stage moves
  always_comb begin
    rdy[LAST+1] = out_o.ready;
    for (int k = LAST; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vld_prev  = {vld_q[LAST-1:1], in_i.valid};
  assign in_i.ready = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= LAST; k++) begin
        if (rdy[k]) vld_q[k] <= vld_prev[k];
      end
    end
  end

  // Phases of every angle needed
  trf_pkg::phase_t ph_u, ph_v, ph_2u, ph_3u, ph_cu, ph_c2u, ph_cv, ph_cw;

  always_comb begin
    ph_u   = trf_pkg::to_phase(in_i.angle_u);
    ph_v   = trf_pkg::to_phase(in_i.angle_v);
    ph_2u  = {ph_u[AB-2:0], 1'b0};
    ph_3u  = ph_u + ph_2u;
    ph_cu  = ph_u + trf_pkg::ANGLE_QUARTER;
    ph_c2u = ph_2u + trf_pkg::ANGLE_QUARTER;
    ph_cv  = ph_v + trf_pkg::ANGLE_QUARTER;
    ph_cw  = ph_v + trf_pkg::ANGLE_THIRD + trf_pkg::ANGLE_QUARTER;
  end

  logic signed [SW-1:0] sin_u, sin_2u, sin_3u, cos_u, cos_2u, cos_v, cos_w;

  trf_sincos u_sin_u   (.clk_i, .en_i(rdy[trf_pkg::ST_SIN:1]), .phase_i(ph_u),
                        .sin_o(sin_u));
  trf_sincos u_sin_2u  (.clk_i, .en_i(rdy[trf_pkg::ST_SIN:1]), .phase_i(ph_2u),
                        .sin_o(sin_2u));
  trf_sincos u_sin_3u  (.clk_i, .en_i(rdy[trf_pkg::ST_SIN:1]), .phase_i(ph_3u),
                        .sin_o(sin_3u));
  trf_sincos u_cos_u   (.clk_i, .en_i(rdy[trf_pkg::ST_SIN:1]), .phase_i(ph_cu),
                        .sin_o(cos_u));
  trf_sincos u_cos_2u  (.clk_i, .en_i(rdy[trf_pkg::ST_SIN:1]), .phase_i(ph_c2u),
                        .sin_o(cos_2u));
  trf_sincos u_cos_v   (.clk_i, .en_i(rdy[trf_pkg::ST_SIN:1]), .phase_i(ph_cv),
                        .sin_o(cos_v));
  trf_sincos u_cos_w   (.clk_i, .en_i(rdy[trf_pkg::ST_SIN:1]), .phase_i(ph_cw),
                        .sin_o(cos_w));

  // Mix stage: denominators, numerator magnitudes and signs
  logic signed [33:0] sy, sa;
  logic [DW-1:0] dv_d, dw_d;
  logic [MW-1:0] xm_d, ym_d;
  logic [31:0]   am_d;
  logic [30:0]   s3_abs;

  always_comb begin
    dv_d   = 32'h8000_0000 + DW'(cos_v);
    dw_d   = 32'h8000_0000 + DW'(cos_w);
    s3_abs = sin_3u[SW-1] ? 31'(-sin_3u) : 31'(sin_3u);
    xm_d   = MW'(s3_abs) << 1;
    sy     = 34'(sin_u) + (34'(sin_2u) <<< 1);
    ym_d   = sy[33] ? (MW'(-sy) << 1) : (MW'(sy) << 1);
    sa     = 34'(cos_u) - (34'(cos_2u) <<< 1);
    am_d   = sa[33] ? 32'(-sa) : 32'(sa);
  end

  logic [DW-1:0] dv7_q, dw7_q;
  logic [MW-1:0] xm7_q, ym7_q;
  logic          xn7_q, yn7_q, an7_q;
  logic [31:0]   am7_q;

  always_ff @(posedge clk_i) begin
    if (rdy[trf_pkg::ST_MIX]) begin
      dv7_q <= dv_d;
      dw7_q <= dw_d;
      xm7_q <= xm_d;
      xn7_q <= sin_3u[SW-1];
      ym7_q <= ym_d;
      yn7_q <= sy[33];
      am7_q <= am_d;
      an7_q <= sa[33];
    end
  end

  // Quotients for x and y
  logic [QW-1:0] qx, qy;
  logic          qx_neg, qy_neg;

  trf_div u_div_x (.clk_i, .en_i(rdy[LAST-1:trf_pkg::ST_DIV0]), .mag_i(xm7_q),
                   .den_i(dv7_q), .neg_i(xn7_q), .quo_o(qx), .neg_o(qx_neg));
  trf_div u_div_y (.clk_i, .en_i(rdy[LAST-1:trf_pkg::ST_DIV0]), .mag_i(ym7_q),
                   .den_i(dw7_q), .neg_i(yn7_q), .quo_o(qy), .neg_o(qy_neg));

  // z: two rounded products, then delay to meet the quotients
  logic [63:0] zp8_q;
  logic [DW-1:0] dw8_q, dw9_q;
  logic          an8_q, an9_q, an10_q;
  logic [26:0]   t2_9_q;
  logic [58:0]   zp10_q;
  trf_pkg::coord_t z11_q;
  trf_pkg::coord_t zd_q [ZD];

  logic [64:0] zt;
  logic [34:0] t2s;
  logic [59:0] zr;
  logic [59:0] zm;

  always_comb begin
    zt  = 65'(zp8_q) + (65'd1 << 29);
    t2s = zt[64:30] + 35'd128;
    zr  = 60'(zp10_q) + (60'd1 << (trf_pkg::Z_SH - 1));
    zm  = zr >> trf_pkg::Z_SH;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[trf_pkg::ST_ZMUL]) begin
      zp8_q <= 64'(am7_q) * 64'(dv7_q);
      dw8_q <= dw7_q;
      an8_q <= an7_q;
    end
    if (rdy[trf_pkg::ST_ZRND]) begin
      t2_9_q <= t2s[34:8];
      dw9_q  <= dw8_q;
      an9_q  <= an8_q;
    end
    if (rdy[trf_pkg::ST_ZPROD]) begin
      zp10_q <= 59'(t2_9_q) * 59'(dw9_q);
      an10_q <= an9_q;
    end
    if (rdy[trf_pkg::ST_ZOUT]) begin
      z11_q <= trf_pkg::sat_coord(an10_q, 64'(zm));
    end
    if (rdy[trf_pkg::ST_ZOUT+1]) begin
      zd_q[0] <= z11_q;
    end
    for (int i = 1; i < ZD; i++) begin
      if (rdy[trf_pkg::ST_ZOUT+1+i]) zd_q[i] <= zd_q[i-1];
    end
  end

  // Output register
  trf_pkg::coord_t px_q, py_q, pz_q;

  always_ff @(posedge clk_i) begin
    if (rdy[LAST]) begin
      px_q <= trf_pkg::sat_coord(qx_neg, 64'(qx));
      py_q <= trf_pkg::sat_coord(qy_neg, 64'(qy));
      pz_q <= zd_q[ZD-1];
    end
  end

  assign out_o.valid   = vld_q[LAST];
  assign out_o.point_x = px_q;
  assign out_o.point_y = py_q;
  assign out_o.point_z = pz_q;

  // A ready sink lets the whole pipeline move
  a_ready_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input stalled while output is ready");

  // An empty first stage always takes a transaction
  a_bubble_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[1] |-> in_i.ready)
    else $error("input stalled with an empty first stage");

  // A full pipeline behind a stalled sink takes nothing more
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !out_o.ready |-> !in_i.ready)
    else $error("input accepted into a full pipeline");

  // A stalled result stays valid next cycle
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid)
    else $error("stalled result dropped");

endmodule

/* rtl/trf_sincos.sv */
// Six-stage pipelined sine: quarter-wave fold, then a 7th-order odd polynomial.
// Depends on trf_pkg for phase width and coefficients.
`timescale 1ns / 1ps

module trf_sincos (
  input  logic                              clk_i,
  input  logic [trf_pkg::ST_SIN-1:0]        en_i,
  input  trf_pkg::phase_t                   phase_i,
  output logic signed [trf_pkg::SIN_W-1:0]  sin_o
);

  localparam int TLOW = 32 - trf_pkg::ANGLE_BITS;
  localparam logic signed [32:0] Q30_ONE   = 33'sd1073741824;
  localparam logic signed [32:0] HALF_TURN = 33'sd2147483648;

  logic [31:0]        t32;
  logic signed [32:0] t33;
  logic signed [32:0] f33;
  logic               tneg_d;
  logic [30:0]        tmag_d;

  logic        s1_neg_q, s2_neg_q, s3_neg_q, s4_neg_q, s5_neg_q;
  logic [30:0] s1_mag_q, s2_mag_q, s3_mag_q, s4_mag_q, s5_mag_q;
  logic [30:0] s2_x2_q, s3_x2_q, s4_x2_q;
  logic [30:0] s3_acc_q, s4_acc_q, s5_acc_q;
  logic signed [trf_pkg::SIN_W-1:0] s6_sin_q;

  logic [61:0] p2, p3, p4, p5, p6;
  logic [30:0] x2_d, acc3_d, acc4_d, acc5_d;
  logic [31:0] m6;
  logic signed [trf_pkg::SIN_W-1:0] sin_d;

  // Fold the phase into [-quarter, +quarter], split into sign and magnitude
  always_comb begin
    t32 = {phase_i, {TLOW{1'b0}}};
    t33 = signed'({t32[31], t32});
    if (t33 > Q30_ONE)       f33 = HALF_TURN - t33;
    else if (t33 < -Q30_ONE) f33 = -HALF_TURN - t33;
    else                     f33 = t33;
    tneg_d = f33[32];
    tmag_d = tneg_d ? 31'(-f33) : 31'(f33);
  end

  // Horner steps, one multiply per stage; all accumulators stay positive
  always_comb begin
    p2     = 62'(s1_mag_q) * 62'(s1_mag_q);
    x2_d   = p2[60:30];
    p3     = 62'(s2_x2_q) * 62'(trf_pkg::POLY_C7);
    acc3_d = trf_pkg::POLY_C5 - p3[60:30];
    p4     = 62'(s3_x2_q) * 62'(s3_acc_q);
    acc4_d = trf_pkg::POLY_C3 - p4[60:30];
    p5     = 62'(s4_x2_q) * 62'(s4_acc_q);
    acc5_d = trf_pkg::POLY_C1 - p5[60:30];
    p6     = 62'(s5_mag_q) * 62'(s5_acc_q);
    m6     = (p6[61:30] > 32'h4000_0000) ? 32'h4000_0000 : p6[61:30];
    sin_d  = s5_neg_q ? -signed'(m6) : signed'(m6);
  end

  // Advance each stage when its enable is set
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_neg_q <= tneg_d;
      s1_mag_q <= tmag_d;
    end
    if (en_i[1]) begin
      s2_neg_q <= s1_neg_q;
      s2_mag_q <= s1_mag_q;
      s2_x2_q  <= x2_d;
    end
    if (en_i[2]) begin
      s3_neg_q <= s2_neg_q;
      s3_mag_q <= s2_mag_q;
      s3_x2_q  <= s2_x2_q;
      s3_acc_q <= acc3_d;
    end
    if (en_i[3]) begin
      s4_neg_q <= s3_neg_q;
      s4_mag_q <= s3_mag_q;
      s4_x2_q  <= s3_x2_q;
      s4_acc_q <= acc4_d;
    end
    if (en_i[4]) begin
      s5_neg_q <= s4_neg_q;
      s5_mag_q <= s4_mag_q;
      s5_acc_q <= acc5_d;
    end
    if (en_i[5]) begin
      s6_sin_q <= sin_d;
    end
  end

  assign sin_o = s6_sin_q;

endmodule

/* rtl/trf_div.sv */
// Pipelined restoring divider, one quotient bit per stage, rounding half up.
// Depends on trf_pkg for operand widths and the quotient length.
`timescale 1ns / 1ps

module trf_div (
  input  logic                         clk_i,
  input  logic [trf_pkg::QUO_W-1:0]    en_i,
  input  logic [trf_pkg::MAG_W-1:0]    mag_i,
  input  logic [trf_pkg::DEN_W-1:0]    den_i,
  input  logic                         neg_i,
  output logic [trf_pkg::QUO_W-1:0]    quo_o,
  output logic                         neg_o
);

  localparam int QW = trf_pkg::QUO_W;
  localparam int DW = trf_pkg::DEN_W;
  localparam int NW = trf_pkg::MAG_W + trf_pkg::OUT_FRAC_BITS + 1;

  logic [NW-1:0] num;

  logic [DW-1:0] rem_s [QW];
  logic [QW-1:0] low_s [QW];
  logic [QW-1:0] quo_s [QW];
  logic [DW-1:0] den_s [QW];
  logic [QW-1:0] neg_s;

  logic [DW:0]   cand  [QW];
  logic [DW-1:0] rem_d [QW];
  logic [QW-1:0] low_d [QW];
  logic [QW-1:0] quo_d [QW];

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] neg_q;

  // Form the rounded dividend and run one trial subtraction per stage
  always_comb begin
    num = {1'b0, mag_i, {trf_pkg::OUT_FRAC_BITS{1'b0}}} + NW'(den_i >> 1);
    rem_s[0] = DW'(num[NW-1:QW]);
    low_s[0] = num[QW-1:0];
    quo_s[0] = '0;
    den_s[0] = den_i;
    neg_s[0] = neg_i;
    for (int j = 1; j < QW; j++) begin
      rem_s[j] = rem_q[j-1];
      low_s[j] = low_q[j-1];
      quo_s[j] = quo_q[j-1];
      den_s[j] = den_q[j-1];
      neg_s[j] = neg_q[j-1];
    end
    for (int j = 0; j < QW; j++) begin
      cand[j]  = {rem_s[j], low_s[j][QW-1]};
      low_d[j] = {low_s[j][QW-2:0], 1'b0};
      if (cand[j] >= {1'b0, den_s[j]}) begin
        rem_d[j] = DW'(cand[j] - {1'b0, den_s[j]});
        quo_d[j] = {quo_s[j][QW-2:0], 1'b1};
      end else begin
        rem_d[j] = cand[j][DW-1:0];
        quo_d[j] = {quo_s[j][QW-2:0], 1'b0};
      end
    end
  end

  // Advance the stages
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QW; j++) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_d[j];
        low_q[j] <= low_d[j];
        quo_q[j] <= quo_d[j];
        den_q[j] <= den_s[j];
        neg_q[j] <= neg_s[j];
      end
    end
  end

  assign quo_o = quo_q[QW-1];
  assign neg_o = neg_q[QW-1];

endmodule

/* verif/testbench.sv */
// Testbench for the trefoil surface point block: directed and random (u, v) pairs
// are checked field by field against a fixed-point predictor of the surface.
// Depends on trf_pkg, trf_in_if, trf_out_if and trefoil_surface_point.
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY    = 27;
  localparam int WATCHDOG   = 20000;
  localparam int RAND_ITEMS = 1350;
  localparam longint Q30    = 64'sd1 << 30;
  localparam int AB         = trf_pkg::ANGLE_BITS;

  typedef struct {
    logic [15:0]      u;
    logic [15:0]      v;
    bit               known;
    trf_pkg::coord_t  x;
    trf_pkg::coord_t  y;
  } stim_row_t;

  typedef struct {
    trf_pkg::coord_t x;
    trf_pkg::coord_t y;
    trf_pkg::coord_t z;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors = 0;
  int   idle_cycles = 0;
  bit   stim_done = 1'b0;
  point_t expected_points[$];

  trf_in_if  in_ch();
  trf_out_if out_ch();

  trefoil_surface_point dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // Signed Q30 product, magnitude truncated toward zero
  function automatic longint mul_q30(longint a, longint b);
    longint unsigned m;
    m = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Quarter-wave polynomial sine of a phase, Q30
  function automatic longint sine_q30(longint unsigned ph);
    longint unsigned t32;
    longint t, x2, acc, s;
    t32 = (ph & ((64'd1 << AB) - 1)) << (32 - AB);
    t = (t32 >= (64'd1 << 31)) ? longint'(t32) - (64'sd1 << 32) : longint'(t32);
    if (t > Q30) t = (64'sd1 << 31) - t;
    else if (t < -Q30) t = -(64'sd1 << 31) - t;
    x2 = mul_q30(t, t);
    acc = longint'(trf_pkg::POLY_C5) - mul_q30(x2, longint'(trf_pkg::POLY_C7));
    acc = longint'(trf_pkg::POLY_C3) - mul_q30(x2, acc);
    acc = longint'(trf_pkg::POLY_C1) - mul_q30(x2, acc);
    s = mul_q30(t, acc);
    if (s > Q30) s = Q30;
    if (s < -Q30) s = -Q30;
    return s;
  endfunction

  function automatic longint cosine_q30(longint unsigned ph);
    return sine_q30(ph + (64'd1 << (AB - 2)));
  endfunction

  // Scale magnitude up to the output format and divide, rounding half up
  function automatic longint scaled_quotient(longint num, longint unsigned den);
    longint unsigned m, q;
    m = (num < 0 ? -num : num) << trf_pkg::OUT_FRAC_BITS;
    q = (m + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic trf_pkg::coord_t clamp_coord(longint val);
    if (val > 524287) return trf_pkg::coord_t'(524287);
    if (val < -524288) return trf_pkg::coord_t'(-524288);
    return trf_pkg::coord_t'(val);
  endfunction

  function automatic point_t surface_point(logic [15:0] au, logic [15:0] av);
    longint unsigned pu, pv, third, dv, dw, t, t2, p, zm;
    longint su, s2u, s3u, cu, c2u, a;
    point_t r;
    pu = (longint'(au) << (AB - 16)) & ((64'd1 << AB) - 1);
    pv = (longint'(av) << (AB - 16)) & ((64'd1 << AB) - 1);
    third = ((64'd1 << AB) + 1) / 3;
    su  = sine_q30(pu);
    s2u = sine_q30(2 * pu);
    s3u = sine_q30(3 * pu);
    cu  = cosine_q30(pu);
    c2u = cosine_q30(2 * pu);
    dv = longint'(2 * Q30 + cosine_q30(pv));
    dw = longint'(2 * Q30 + cosine_q30(pv + third));
    r.x = clamp_coord(scaled_quotient(2 * s3u, dv));
    r.y = clamp_coord(scaled_quotient(2 * (su + 2 * s2u), dw));
    a = cu - 2 * c2u;
    t = ((a < 0 ? -a : a) * dv + (64'd1 << 29)) >> 30;
    t2 = (t + 128) >> 8;
    p = t2 * dw;
    zm = (p + (64'd1 << (trf_pkg::Z_SH - 1))) >> trf_pkg::Z_SH;
    r.z = clamp_coord(a < 0 ? -longint'(zm) : longint'(zm));
    return r;
  endfunction

  // Random gap: most often none, else a short one, now and then a long one
  function automatic int gap_length();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Directed rows: extremes, axes, -pi and near +pi; known x and y at u = v = 0
  stim_row_t directed[$] = '{
    '{16'h0000, 16'h0000, 1'b1, 20'sd0, 20'sd0},
    '{16'h8000, 16'h0000, 1'b0, 0, 0},
    '{16'h7FFF, 16'h7FFF, 1'b0, 0, 0},
    '{16'h8000, 16'h8000, 1'b0, 0, 0},
    '{16'hFFFF, 16'hFFFF, 1'b0, 0, 0},
    '{16'h0001, 16'h0001, 1'b0, 0, 0},
    '{16'h4000, 16'h0000, 1'b0, 0, 0},
    '{16'hC000, 16'h4000, 1'b0, 0, 0},
    '{16'h2000, 16'hC000, 1'b0, 0, 0},
    '{16'h2AAB, 16'h5555, 1'b0, 0, 0},
    '{16'hD555, 16'hAAAB, 1'b0, 0, 0},
    '{16'h5555, 16'h8000, 1'b0, 0, 0},
    '{16'hAAAA, 16'h7FFF, 1'b0, 0, 0},
    '{16'h1000, 16'h6000, 1'b0, 0, 0},
    '{16'hF000, 16'hA000, 1'b0, 0, 0},
    '{16'h5A5A, 16'hA5A5, 1'b0, 0, 0}
  };

  // Drop valid only for a real gap; back-to-back sends go once per edge while ready
  task automatic send_pair(logic [15:0] au, logic [15:0] av);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.angle_u <= au;
    in_ch.angle_v <= av;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Drive stimulus and queue expectations at acceptance
  initial begin
    point_t pt;
    in_ch.valid   = 1'b0;
    in_ch.angle_u = '0;
    in_ch.angle_v = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_pair(directed[i].u, directed[i].v);
      pt = surface_point(directed[i].u, directed[i].v);
      if (directed[i].known) begin
        pt.x = directed[i].x;
        pt.y = directed[i].y;
      end
      expected_points.push_back(pt);
    end
    for (int n = 0; n < RAND_ITEMS; n++) begin
      logic [15:0] au, av;
      au = 16'($urandom);
      av = 16'($urandom);
      send_pair(au, av);
      expected_points.push_back(surface_point(au, av));
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Random stalls on the output side, with stretches of constant ready
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(30, 1)) @(posedge clk_i);
      gap = gap_length();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result: x=%0d y=%0d z=%0d",
               out_ch.point_x, out_ch.point_y, out_ch.point_z);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (out_ch.point_x !== want.x) begin
          $error("point_x: expected %0d, got %0d", want.x, out_ch.point_x);
          errors++;
        end
        if (out_ch.point_y !== want.y) begin
          $error("point_y: expected %0d, got %0d", want.y, out_ch.point_y);
          errors++;
        end
        if (out_ch.point_z !== want.z) begin
          $error("point_z: expected %0d, got %0d", want.z, out_ch.point_z);
          errors++;
        end
      end
    end
  end

  // Count cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Finish once drained, or on the watchdog
  initial begin
    fork
      begin
        wait (stim_done && expected_points.size() == 0);
        repeat (LATENCY + 10) @(posedge clk_i);
      end
      wait (idle_cycles >= WATCHDOG);
    join_any
    if (idle_cycles >= WATCHDOG) errors++;
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
